@@ hw/rtl/response_header_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Response header parser: assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH
`define RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH

// Assert a property on the rising edge, held off while reset is low
`define RHP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the rising edge with no reset qualifier
`define RHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rhp_pkg.sv @@
// ----------------------------------------------------------------------------
// Response header parser package
// Phase and status codes, parser state struct and literal text tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhp_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int LIT_W      = 4;
    localparam int CNT_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: index taken from paddr[2]
    localparam logic REG_IDX_MAX_PAYLOAD = 1'b0;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd5000;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [LIT_W-1:0] HEAD_LEN = 4'd8;
    localparam logic [LIT_W-1:0] EXP_LEN  = 4'd7;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_EXPIRE_LIT,
        PH_EXP_FIRST,
        PH_EXP_NEG,
        PH_EXP_MORE,
        PH_EXP_ZERO,
        PH_END_NL,
        PH_PAYLOAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HEADER  = 3'd0,
        ST_PAYLOAD = 3'd1,
        ST_FINAL   = 3'd2,
        ST_ERROR   = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [LIT_W-1:0]   lit_pos;
        logic [LEN_W-1:0]   length_acc;
        logic [CNT_W-1:0]   digit_cnt;
        logic [LEN_W-1:0]   remaining;
    } parse_state_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_length;
        logic                message_done;
    } step_result_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:      PH_HEADER,
        lit_pos:    '0,
        length_acc: '0,
        digit_cnt:  '0,
        remaining:  '0
    };

    // Fixed header text "200\nLen "
    function automatic logic [BYTE_W-1:0] head_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h32;
            3'd1:    ch = 8'h30;
            3'd2:    ch = 8'h30;
            3'd3:    ch = 8'h0A;
            3'd4:    ch = 8'h4C;
            3'd5:    ch = 8'h65;
            3'd6:    ch = 8'h6E;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    // Expire label text "Expire "
    function automatic logic [BYTE_W-1:0] exp_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h45;
            3'd1:    ch = 8'h78;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h65;
            3'd6:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/rhp_parse.sv @@
// ----------------------------------------------------------------------------
// Response header parser: byte step logic
// Next parser state and result for one byte, given the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhp_parse #(
    parameter int LENGTH_BITS       = 16,
    parameter int MAX_EXPIRE_DIGITS = 10
) (
    input  rhp_pkg::parse_state_t          state_cur,
    input  logic [rhp_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           first_byte,
    input  logic [rhp_pkg::LEN_W-1:0]      max_payload,
    output rhp_pkg::parse_state_t          state_next,
    output rhp_pkg::step_result_t          result_next
);
    import rhp_pkg::*;

    localparam int CAP_BITS = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((64'd1 << CAP_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] EXP_MAX = CNT_W'(MAX_EXPIRE_DIGITS);
    localparam int PROD_W = LEN_W + 4;

    parse_state_t        st;
    logic                is_digit;
    logic                head_ok;
    logic                exp_ok;
    logic [LEN_W-1:0]    len_limit;
    logic [PROD_W-1:0]   len_value;
    logic                len_fits;
    logic [LEN_W-1:0]    rem_dec;
    status_t             status_sel;
    logic [BYTE_W-1:0]   pay_sel;

    // Apply a start mark before the byte is looked at
    assign st = first_byte ? PARSE_STATE_RESET : state_cur;

    // Shared byte classification and length arithmetic
    assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign head_ok   = !st.lit_pos[3] && (data_byte == head_char(st.lit_pos[2:0]));
    assign exp_ok    = (st.lit_pos < EXP_LEN) && (data_byte == exp_char(st.lit_pos[2:0]));
    assign len_limit = (max_payload < LEN_CAP) ? max_payload : LEN_CAP;
    assign len_value = (PROD_W'(st.length_acc) << 3) + (PROD_W'(st.length_acc) << 1)
                     + PROD_W'(data_byte[3:0]);
    assign len_fits  = (len_value <= PROD_W'(len_limit));
    assign rem_dec   = (st.remaining != '0) ? (st.remaining - LEN_W'(1)) : st.remaining;

    // Next state
    always_comb
    begin
        state_next = st;
        case (st.phase)
            PH_HEADER:
            begin
                if (head_ok)
                begin
                    if ((st.lit_pos + LIT_W'(1)) == HEAD_LEN)
                    begin
                        state_next.lit_pos = '0;
                        state_next.phase   = PH_LEN_FIRST;
                    end
                    else
                    begin
                        state_next.lit_pos = st.lit_pos + LIT_W'(1);
                    end
                end
                else
                begin
                    state_next.phase = PH_ERROR;
                end
            end
            PH_LEN_FIRST, PH_LEN_MORE:
            begin
                if ((st.phase == PH_LEN_MORE) && (data_byte == CH_NL))
                begin
                    state_next.phase     = PH_EXPIRE_LIT;
                    state_next.lit_pos   = '0;
                    state_next.digit_cnt = '0;
                end
                else if (!is_digit || !len_fits ||
                         ((st.phase == PH_LEN_MORE) && (st.length_acc == '0)))
                begin
                    state_next.phase = PH_ERROR;
                end
                else
                begin
                    state_next.length_acc = len_value[LEN_W-1:0];
                    state_next.phase      = PH_LEN_MORE;
                end
            end
            PH_EXPIRE_LIT:
            begin
                if (exp_ok)
                begin
                    if ((st.lit_pos + LIT_W'(1)) == EXP_LEN)
                    begin
                        state_next.lit_pos = '0;
                        state_next.phase   = PH_EXP_FIRST;
                    end
                    else
                    begin
                        state_next.lit_pos = st.lit_pos + LIT_W'(1);
                    end
                end
                else
                begin
                    state_next.phase = PH_ERROR;
                end
            end
            PH_EXP_FIRST:
            begin
                if (data_byte == CH_DASH)
                begin
                    state_next.phase = PH_EXP_NEG;
                end
                else if (data_byte == CH_ZERO)
                begin
                    state_next.phase = PH_EXP_ZERO;
                end
                else if (is_digit)
                begin
                    state_next.digit_cnt = CNT_W'(1);
                    state_next.phase     = PH_EXP_MORE;
                end
                else
                begin
                    state_next.phase = PH_ERROR;
                end
            end
            PH_EXP_NEG:
            begin
                if (is_digit && (data_byte != CH_ZERO))
                begin
                    state_next.digit_cnt = CNT_W'(1);
                    state_next.phase     = PH_EXP_MORE;
                end
                else
                begin
                    state_next.phase = PH_ERROR;
                end
            end
            PH_EXP_MORE:
            begin
                if (data_byte == CH_NL)
                begin
                    state_next.phase = PH_END_NL;
                end
                else if (is_digit && (st.digit_cnt < EXP_MAX))
                begin
                    state_next.digit_cnt = st.digit_cnt + CNT_W'(1);
                end
                else
                begin
                    state_next.phase = PH_ERROR;
                end
            end
            PH_EXP_ZERO:
            begin
                state_next.phase = (data_byte == CH_NL) ? PH_END_NL : PH_ERROR;
            end
            PH_END_NL:
            begin
                if (data_byte != CH_NL)
                begin
                    state_next.phase = PH_ERROR;
                end
                else if (st.length_acc == '0)
                begin
                    state_next.phase = PH_DONE;
                end
                else
                begin
                    state_next.remaining = st.length_acc;
                    state_next.phase     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                state_next.remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    state_next.phase = PH_DONE;
                end
            end
            PH_DONE:
            begin
                state_next.phase = PH_DONE;
            end
            default:
            begin
                state_next.phase = st.phase;
            end
        endcase
    end

    // Result for this byte
    always_comb
    begin
        pay_sel = '0;
        case (st.phase)
            PH_DONE:
            begin
                status_sel = ST_IGNORED;
            end
            PH_PAYLOAD:
            begin
                pay_sel    = data_byte;
                status_sel = (rem_dec == '0) ? ST_FINAL : ST_PAYLOAD;
            end
            PH_END_NL:
            begin
                if (data_byte != CH_NL)
                begin
                    status_sel = ST_ERROR;
                end
                else
                begin
                    status_sel = (st.length_acc == '0) ? ST_FINAL : ST_HEADER;
                end
            end
            PH_ERROR:
            begin
                status_sel = ST_ERROR;
            end
            PH_HEADER, PH_LEN_FIRST, PH_LEN_MORE, PH_EXPIRE_LIT,
            PH_EXP_FIRST, PH_EXP_NEG, PH_EXP_MORE, PH_EXP_ZERO:
            begin
                status_sel = (state_next.phase == PH_ERROR) ? ST_ERROR : ST_HEADER;
            end
            default:
            begin
                status_sel = ST_ERROR;
            end
        endcase
    end

    assign result_next.status         = status_sel;
    assign result_next.payload_byte   = pay_sel;
    assign result_next.payload_length = state_next.length_acc;
    assign result_next.message_done   = (status_sel == ST_FINAL);

endmodule

@@ hw/rtl/response_header_parser_unit.sv @@
// The result passes through the input register, then the result register, before it is
// offered on the output channel.
// Throughput: one byte per cycle while the result is not stalled; the state loop holds only state_reg.
// A stalled result holds the next byte in the input register; in_ready drops only while
// both registers are full. Reset (rst_n low, asynchronous) empties both stages, sets the
// parser to expect the status code and loads max_payload with 5000.
// ----------------------------------------------------------------------------
// Response header parser
// Checks the response header byte by byte and passes the payload through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module response_header_parser_unit #(
    parameter int LENGTH_BITS       = 16,
    parameter int MAX_EXPIRE_DIGITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rhp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rhp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rhp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rhp_pkg::BYTE_W-1:0]         data_byte,
    input  logic                               first_byte,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rhp_pkg::STATUS_W-1:0]       status,
    output logic [rhp_pkg::BYTE_W-1:0]         payload_byte,
    output logic [rhp_pkg::LEN_W-1:0]          payload_length,
    output logic                               message_done
);
    import rhp_pkg::*;

    logic [LEN_W-1:0]    max_payload_reg;
    logic                cfg_write;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_data_reg;
    logic                in_first_reg;
    logic                advance;
    logic                in_take;

    parse_state_t        state_reg;
    parse_state_t        state_next;
    step_result_t        result_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    step_result_t        result_reg;

    // Configuration register write and read back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX_PAYLOAD);
    assign prdata    = (paddr[2] == REG_IDX_MAX_PAYLOAD)
                     ? APB_DATA_W'(max_payload_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            max_payload_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Handshake: advance the input stage whenever the result stage can take it
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg  <= data_byte;
            in_first_reg <= first_byte;
        end
    end

    // Byte step logic
    rhp_parse #(
        .LENGTH_BITS       (LENGTH_BITS),
        .MAX_EXPIRE_DIGITS (MAX_EXPIRE_DIGITS)
    ) u_parse (
        .state_cur   (state_reg),
        .data_byte   (in_data_reg),
        .first_byte  (in_first_reg),
        .max_payload (max_payload_reg),
        .state_next  (state_next),
        .result_next (result_next)
    );

    // Parser state: commit when the byte moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Drive the output ports
    assign out_valid      = out_valid_reg;
    assign status         = STATUS_W'(result_reg.status);
    assign payload_byte   = result_reg.payload_byte;
    assign payload_length = result_reg.payload_length;
    assign message_done   = result_reg.message_done;

endmodule

@@ hw/rtl/rhp_checker.sv @@
// ----------------------------------------------------------------------------
// Response header parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "response_header_parser_unit_macros.svh"

module rhp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [rhp_pkg::STATUS_W-1:0]   status,
    input  logic [rhp_pkg::BYTE_W-1:0]     payload_byte,
    input  logic                           message_done
);
    import rhp_pkg::*;

    // Completion flag tracks the final-byte status
    `RHP_ASSERT_CLK(a_done_matches_final, clk, rst_n, out_valid |-> (message_done == (status == ST_FINAL)), "message_done disagrees with status")

    // Payload data is zero outside payload and final transactions
    `RHP_ASSERT_CLK(a_payload_zero, clk, rst_n, (out_valid && (status != ST_PAYLOAD) && (status != ST_FINAL)) |-> (payload_byte == '0), "payload_byte nonzero on a header transaction")

    // Status code stays within the defined set
    `RHP_ASSERT_CLK(a_status_range, clk, rst_n, out_valid |-> ((status == ST_HEADER) || (status == ST_PAYLOAD) || (status == ST_FINAL) || (status == ST_ERROR) || (status == ST_IGNORED)), "status code out of range")

    // Hold a stalled result
    `RHP_ASSERT_CLK(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(payload_byte)), "stalled result changed")

endmodule

bind response_header_parser_unit rhp_checker u_rhp_checker (.*);
